// ===== sv/key_debounce_repeat_queue_assert.svh =====
// ----------------------------------------------------------------------------
// key debounce repeat queue assertion macros
// concurrent assertion helpers clocked on clk, disabled during reset
// ----------------------------------------------------------------------------
`ifndef KEY_DEBOUNCE_REPEAT_QUEUE_ASSERT_SVH
`define KEY_DEBOUNCE_REPEAT_QUEUE_ASSERT_SVH

`ifndef ASSERT_OFF

// property that must hold at every clock edge outside reset
`define KDRQ_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// implication checked in the same cycle
`define KDRQ_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`else

`define KDRQ_ASSERT_ALWAYS(label, expr, msg)
`define KDRQ_ASSERT_IMPL(label, ante, cons, msg)

`endif

`endif

// ===== sv/kdrq_pkg.sv =====
// ----------------------------------------------------------------------------
// kdrq_pkg
// shared types and constants of the key debounce repeat queue
// ----------------------------------------------------------------------------
package kdrq_pkg;

    // field widths
    localparam int KEY_W    = 16;
    localparam int GUARD_W  = 5;
    localparam int REPEAT_W = 6;
    localparam int CFG_IDX_W = 2;

    // parameter defaults
    localparam int KEY_COUNT_DEF   = 16;
    localparam int QUEUE_DEPTH_DEF = 4;

    // counter limits
    localparam logic [GUARD_W-1:0]  GUARD_MAX  = 5'd30;
    localparam logic [REPEAT_W-1:0] REPEAT_MAX = 6'd63;

    // register reset values
    localparam logic [KEY_W-1:0]    REPEAT_MASK_RST  = 16'h0000;
    localparam logic [GUARD_W-1:0]  PRESS_GAP_RST    = 5'd20;
    localparam logic [REPEAT_W-1:0] REPEAT_START_RST = 6'd50;
    localparam logic [REPEAT_W-1:0] REPEAT_RELOAD_RST = 6'd30;

    // input item kinds
    localparam logic ACTION_TICK = 1'b0;
    localparam logic ACTION_POP  = 1'b1;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_REPEAT_MASK   = 2'd0,
        CFG_PRESS_GAP     = 2'd1,
        CFG_REPEAT_START  = 2'd2,
        CFG_REPEAT_RELOAD = 2'd3
    } cfg_index_t;

    // queue control from the qualifier
    typedef struct packed {
        logic push;
        logic pop;
    } queue_ctl_t;

    // queue status back to the qualifier
    typedef struct packed {
        logic full;
        logic empty;
    } queue_sts_t;

endpackage

// ===== sv/key_debounce_repeat_queue.sv =====
// ----------------------------------------------------------------------------
// key_debounce_repeat_queue
// keypad qualifier with auto-repeat and a small key event queue
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one transaction per tick or pop. s_tuser is the action
//   (0 = tick with raw sample in s_tdata, 1 = pop the queue head).
//   m_* returns exactly one result per input transaction, in order.
//   cfg_* writes the repeat mask, press gap, repeat start and reload
//   registers; cfg_ready is always high, write only while the block is idle.
// Timing:
//   every item is handled in combinational logic between the state
//   registers and the result register: m_tvalid rises in the cycle after
//   acceptance, and one item is accepted per cycle while m_tready is high.
//   the result register decouples the sides: s_tready is high while the
//   result register is empty or being taken this cycle.
// Reset:
//   rst_n clears the key state, counters and queue and loads the register
//   defaults (mask 0, gap 20, start 50, reload 30). No clearing pass.
// Stall:
//   while m_tready is low a waiting result holds and s_tready drops.
// ----------------------------------------------------------------------------
module key_debounce_repeat_queue #(
    parameter int KEY_COUNT   = kdrq_pkg::KEY_COUNT_DEF,
    parameter int QUEUE_DEPTH = kdrq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    // input stream
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [15:0]                  s_tdata,   // [15:0] raw_keys
    input  logic                         s_tuser,   // [0] action
    // output stream
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // [15:0] popped_key, [31:16] pressed_key, [32] pushed, [33] dropped
    output logic [39:0]                  m_tdata,
    // configuration writes
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  kdrq_pkg::cfg_index_t         cfg_index,
    input  logic [kdrq_pkg::KEY_W-1:0]   cfg_data
);
    import kdrq_pkg::*;

    localparam logic [KEY_W-1:0] KEY_MASK =
        (KEY_COUNT >= KEY_W) ? {KEY_W{1'b1}} : KEY_W'((64'd1 << KEY_COUNT) - 64'd1);

    // configuration registers
    logic [KEY_W-1:0]    repeat_mask_reg;
    logic [GUARD_W-1:0]  press_gap_reg;
    logic [REPEAT_W-1:0] repeat_start_reg;
    logic [REPEAT_W-1:0] repeat_reload_reg;

    // qualifier state
    logic [KEY_W-1:0]    prev_raw_reg,   prev_raw_next;
    logic [KEY_W-1:0]    cur_key_reg,    cur_key_next;
    logic [REPEAT_W-1:0] repeat_cnt_reg, repeat_cnt_next;
    logic [GUARD_W-1:0]  guard_cnt_reg,  guard_cnt_next;

    // result register
    logic                out_valid_reg;
    logic [KEY_W-1:0]    out_popped_reg;
    logic [KEY_W-1:0]    out_pressed_reg;
    logic                out_pushed_reg,  out_pushed_next;
    logic                out_dropped_reg, out_dropped_next;

    logic                in_accept;
    logic                key_event;
    logic [KEY_W-1:0]    raw;
    logic [KEY_W-1:0]    low_key;
    logic [GUARD_W-1:0]  guard_inc;
    logic [REPEAT_W-1:0] repeat_inc;
    logic [KEY_W-1:0]    head_key;
    queue_ctl_t          q_ctl;
    queue_sts_t          q_sts;

    // handshakes
    assign s_tready  = !out_valid_reg || m_tready;
    assign in_accept = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    // configuration write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            repeat_mask_reg   <= REPEAT_MASK_RST;
            press_gap_reg     <= PRESS_GAP_RST;
            repeat_start_reg  <= REPEAT_START_RST;
            repeat_reload_reg <= REPEAT_RELOAD_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_REPEAT_MASK:   repeat_mask_reg   <= cfg_data;
                CFG_PRESS_GAP:     press_gap_reg     <= cfg_data[GUARD_W-1:0];
                CFG_REPEAT_START:  repeat_start_reg  <= cfg_data[REPEAT_W-1:0];
                CFG_REPEAT_RELOAD: repeat_reload_reg <= cfg_data[REPEAT_W-1:0];
                default: ;
            endcase
        end
    end

    // tick qualification: debounce, new key guard, auto-repeat
    assign raw        = s_tdata & KEY_MASK;
    assign low_key    = raw & (~raw + KEY_W'(1));
    assign guard_inc  = (guard_cnt_reg < GUARD_MAX) ? guard_cnt_reg + GUARD_W'(1)
                                                    : guard_cnt_reg;
    assign repeat_inc = (repeat_cnt_reg < REPEAT_MAX) ? repeat_cnt_reg + REPEAT_W'(1)
                                                      : repeat_cnt_reg;

    always_comb
    begin
        prev_raw_next   = prev_raw_reg;
        cur_key_next    = cur_key_reg;
        repeat_cnt_next = repeat_cnt_reg;
        guard_cnt_next  = guard_cnt_reg;
        key_event       = 1'b0;
        if (s_tuser == ACTION_TICK)
        begin
            guard_cnt_next = guard_inc;
            if (raw != prev_raw_reg)
            begin
                prev_raw_next = raw;
            end
            else if (raw == '0)
            begin
                cur_key_next = '0;
            end
            else
            begin
                cur_key_next = low_key;
                if (cur_key_reg == low_key)
                begin
                    // held key
                    repeat_cnt_next = repeat_inc;
                    if (repeat_inc >= repeat_start_reg)
                    begin
                        repeat_cnt_next = repeat_reload_reg;
                        key_event       = |(low_key & repeat_mask_reg);
                    end
                end
                else
                begin
                    // new key
                    repeat_cnt_next = '0;
                    if (guard_inc >= press_gap_reg)
                    begin
                        guard_cnt_next = '0;
                        key_event      = 1'b1;
                    end
                end
            end
        end
    end

    // queue control and result flags
    assign q_ctl.push       = in_accept && key_event && !q_sts.full;
    assign q_ctl.pop        = in_accept && (s_tuser == ACTION_POP);
    assign out_pushed_next  = key_event && !q_sts.full;
    assign out_dropped_next = key_event && q_sts.full;

    kdrq_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (q_ctl),
        .push_key (low_key),
        .head_key (head_key),
        .sts      (q_sts)
    );

    // state update on an accepted transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_raw_reg   <= '0;
            cur_key_reg    <= '0;
            repeat_cnt_reg <= '0;
            guard_cnt_reg  <= '0;
        end
        else if (in_accept)
        begin
            prev_raw_reg   <= prev_raw_next;
            cur_key_reg    <= cur_key_next;
            repeat_cnt_reg <= repeat_cnt_next;
            guard_cnt_reg  <= guard_cnt_next;
        end
    end

    // result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            out_valid_reg <= s_tvalid;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            out_popped_reg  <= (s_tuser == ACTION_POP) ? head_key : '0;
            out_pressed_reg <= cur_key_next;
            out_pushed_reg  <= out_pushed_next;
            out_dropped_reg <= out_dropped_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b000000, out_dropped_reg, out_pushed_reg,
                       out_pressed_reg, out_popped_reg};

    // assertions
`include "key_debounce_repeat_queue_assert.svh"

    `KDRQ_ASSERT_IMPL(a_pressed_onehot, m_tvalid, $onehot0(out_pressed_reg), "pressed key not one-hot")
    `KDRQ_ASSERT_IMPL(a_popped_onehot, m_tvalid, $onehot0(out_popped_reg), "popped key not one-hot")
    `KDRQ_ASSERT_ALWAYS(a_push_xor_drop, !(out_pushed_reg && out_dropped_reg && m_tvalid), "pushed and dropped together")
    `KDRQ_ASSERT_IMPL(a_push_not_full, q_ctl.push, !q_sts.full && !q_ctl.pop, "push into full queue or with pop")

endmodule

// ===== sv/kdrq_queue.sv =====
// ----------------------------------------------------------------------------
// kdrq_queue
// packed key event fifo, slot 0 is the head, pushes fill the lowest free slot
// ----------------------------------------------------------------------------
module kdrq_queue #(
    parameter int QUEUE_DEPTH = kdrq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  kdrq_pkg::queue_ctl_t     ctl,
    input  logic [kdrq_pkg::KEY_W-1:0] push_key,
    output logic [kdrq_pkg::KEY_W-1:0] head_key,
    output kdrq_pkg::queue_sts_t     sts
);
    import kdrq_pkg::*;

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    logic [KEY_W-1:0] slot_reg [QUEUE_DEPTH];
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    // status and head, empty head reads as zero
    assign sts.full  = (count_reg == CNT_FULL);
    assign sts.empty = (count_reg == '0);
    assign head_key  = sts.empty ? '0 : slot_reg[0];

    // fill count
    always_comb
    begin
        count_next = count_reg;
        if (ctl.push && !sts.full)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (ctl.pop && !sts.empty)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // slot storage: write at the fill count, shift down on pop
    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_slot
        always_ff @(posedge clk)
        begin
            if (ctl.push && !sts.full && (count_reg == CNT_W'(i)))
            begin
                slot_reg[i] <= push_key;
            end
            else if (ctl.pop && !sts.empty && (i + 1 < QUEUE_DEPTH))
            begin
                slot_reg[i] <= slot_reg[(i + 1) % QUEUE_DEPTH];
            end
        end
    end

endmodule
